>>> rtl/snp_pkg.sv
// ----------------------------------------------------------------------------
// snp_pkg
// Types, register indexes and defaults shared by the neuron block.
// ----------------------------------------------------------------------------
package snp_pkg;

	localparam int MAX_CONNS_DEF   = 256;
	localparam int NUM_SOURCES_DEF = 64;
	localparam int FRAC_BITS_DEF   = 8;

	// configuration register indexes
	localparam logic [2:0] REG_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_REFRACT   = 3'd1;
	localparam logic [2:0] REG_RANGE     = 3'd2;
	localparam logic [2:0] REG_PLASTIC   = 3'd3;
	localparam logic [2:0] REG_POT_STEP  = 3'd4;
	localparam logic [2:0] REG_DEP_STEP  = 3'd5;
	localparam logic [2:0] REG_LIMIT     = 3'd6;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ILLEGAL = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// input op codes
	localparam logic OP_CONNECT = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	typedef struct packed {
		logic              op;
		logic [5:0]        source;
		logic signed [7:0] init_weight;
		logic [63:0]       fired_sources;
	} in_t;

	typedef struct packed {
		logic       spike;
		logic [1:0] status;
		logic [8:0] live_connections;
	} out_t;

	typedef struct packed {
		logic [22:0] fire_threshold;
		logic [7:0]  refractory_ticks;
		logic [6:0]  weight_range;
		logic        plastic_enable;
		logic [14:0] potentiation_step;
		logic [14:0] depression_step;
		logic [8:0]  connection_limit;
	} cfg_t;

endpackage

>>> rtl/spiking_neuron_with_plasticity.sv
// ----------------------------------------------------------------------------
// spiking_neuron_with_plasticity
// Integrate-and-fire neuron with a connection table and Hebbian plasticity.
// ----------------------------------------------------------------------------
// Connect beat: result registered in the cycle after acceptance.
// Tick beat: an accumulate pass over the N connections, then the threshold
// decision; a plastic spike adds an update pass over the connections and a
// pass that moves the C split copies behind the survivors. Not ready while a
// beat is in work or a result waits. Reset clears count, potential,
// refractory count, registers.
module spiking_neuron_with_plasticity import snp_pkg::*; #(
	parameter int MAX_CONNS   = MAX_CONNS_DEF,
	parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [22:0] cfg_data
);

	localparam int FRAC_BITS = FRAC_BITS_DEF;
	localparam int AW = $clog2(MAX_CONNS);
	localparam int CW = $clog2(MAX_CONNS + 1);
	localparam int WW = 8 + FRAC_BITS;     // stored weight width
	localparam int EW = WW + 2;            // working weight width
	localparam int RW = 6 + WW;            // ram word: source, weight

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ACC  = 3'd1;
	localparam logic [2:0] S_DEC  = 3'd2;
	localparam logic [2:0] S_PL   = 3'd3;
	localparam logic [2:0] S_CP   = 3'd4;

	cfg_t cfg;

	snp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	logic [2:0]           state_q;
	logic [63:0]          bits_q;
	logic [CW-1:0]        cnt_q, rd_q, wr_q, ncp_q, live_q;
	logic                 pend_s1;
	logic signed [23:0]   pot_q;
	logic [7:0]           refr_q;
	logic                 spike_q;
	logic                 ovalid_q;
	out_t                 odata_q;

	// table RAMs
	logic                 m_we, c_we;
	logic [AW-1:0]        m_waddr, c_waddr;
	logic [RW-1:0]        m_wdata, c_wdata, m_rdata, c_rdata;

	snp_ram #(.W(RW), .D(MAX_CONNS)) u_main (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (rd_q[AW-1:0]),
		.rdata (m_rdata)
	);

	snp_ram #(.W(RW), .D(MAX_CONNS)) u_copy (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (rd_q[AW-1:0]),
		.rdata (c_rdata)
	);

	assign in_ready  = (state_q == S_IDLE) && !ovalid_q;
	assign out_valid = ovalid_q;
	assign out_data  = odata_q;

	// effective split limit
	logic [CW-1:0] lim;
	always_comb begin
		if (32'(cfg.connection_limit) >= MAX_CONNS) lim = CW'(MAX_CONNS);
		else lim = CW'(cfg.connection_limit);
	end

	// connect check
	logic signed [8:0] cw_s, cr_s, csum_s;
	logic              c_illegal, c_full;
	always_comb begin
		cw_s      = {in_data.init_weight[7], in_data.init_weight};
		cr_s      = {2'b00, cfg.weight_range};
		csum_s    = cw_s + cr_s;
		c_illegal = (cw_s == 9'sd0) || (cw_s > cr_s) || csum_s[8];
		c_full    = (32'(cnt_q) >= MAX_CONNS);
	end

	// fields of the word being read
	logic [5:0]           r_src;
	logic signed [WW-1:0] r_w;
	logic                 r_fired;
	assign r_src   = m_rdata[RW-1:WW];
	assign r_w     = m_rdata[WW-1:0];
	assign r_fired = (32'(r_src) < NUM_SOURCES) && bits_q[r_src];

	// arithmetic unit: saturating accumulate
	logic signed [24:0] acc_sum;
	logic signed [23:0] acc_sat;
	always_comb begin
		acc_sum = {pot_q[23], pot_q} + 25'(r_w);
		if (acc_sum > 25'sd8388607) acc_sat = 24'sd8388607;
		else if (acc_sum < -25'sd8388608) acc_sat = -24'sd8388608;
		else acc_sat = acc_sum[23:0];
	end

	// plasticity update of one weight
	logic signed [EW-1:0] w_e, w_up, w_dn, range_q, w_new;
	logic                 pl_keep, pl_copy;
	always_comb begin
		w_e     = EW'(r_w);
		range_q = $signed({3'b000, cfg.weight_range, {FRAC_BITS{1'b0}}});
		w_up    = w_e + $signed({{(EW-15){1'b0}}, cfg.potentiation_step});
		w_dn    = w_e - $signed({{(EW-15){1'b0}}, cfg.depression_step});
		w_new   = w_e;
		pl_keep = 1'b1;
		pl_copy = 1'b0;
		if (w_e > 0) begin
			if (r_fired) begin
				w_new = w_up;
				if (w_up > range_q) begin
					if (live_q < lim) begin
						w_new   = w_up >>> 1;
						pl_copy = 1'b1;
					end else begin
						w_new = range_q;
					end
				end
			end else begin
				w_new   = w_dn;
				pl_keep = !w_dn[EW-1];
			end
		end
	end

	logic signed [24:0] pot_e, thr_e;
	logic               at_thr;
	assign pot_e  = {pot_q[23], pot_q};
	assign thr_e  = $signed({2'b00, cfg.fire_threshold});
	assign at_thr = pot_e >= thr_e;

	// RAM write selection
	always_comb begin
		m_we    = 1'b0;
		m_waddr = wr_q[AW-1:0];
		m_wdata = {r_src, w_new[WW-1:0]};
		c_we    = 1'b0;
		c_waddr = ncp_q[AW-1:0];
		c_wdata = {r_src, w_new[WW-1:0]};
		unique case (state_q)
			S_IDLE: begin
				m_waddr = cnt_q[AW-1:0];
				m_wdata = {in_data.source, in_data.init_weight, {FRAC_BITS{1'b0}}};
				m_we    = in_valid && in_ready && (in_data.op == OP_CONNECT)
				          && !c_illegal && !c_full;
			end
			S_PL: begin
				m_we = pend_s1 && pl_keep;
				c_we = pend_s1 && pl_copy;
			end
			S_CP: begin
				m_we    = pend_s1;
				m_wdata = c_rdata;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			rd_q     <= '0;
			wr_q     <= '0;
			ncp_q    <= '0;
			live_q   <= '0;
			pend_s1  <= 1'b0;
			pot_q    <= '0;
			refr_q   <= '0;
			spike_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			pend_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						if (in_data.op == OP_CONNECT) begin
							odata_q.spike <= 1'b0;
							if (c_illegal) begin
								odata_q.status           <= ST_ILLEGAL;
								odata_q.live_connections <= 9'(cnt_q);
							end else if (c_full) begin
								odata_q.status           <= ST_FULL;
								odata_q.live_connections <= 9'(cnt_q);
							end else begin
								odata_q.status           <= ST_OK;
								odata_q.live_connections <= 9'(cnt_q + 1'b1);
								cnt_q                    <= cnt_q + 1'b1;
							end
							ovalid_q <= 1'b1;
						end else begin
							bits_q  <= in_data.fired_sources;
							rd_q    <= '0;
							spike_q <= 1'b0;
							state_q <= S_ACC;
						end
					end
				end
				S_ACC: begin
					if (rd_q < cnt_q) begin
						rd_q    <= rd_q + 1'b1;
						pend_s1 <= 1'b1;
					end
					if (pend_s1 && r_fired) pot_q <= acc_sat;
					if (rd_q == cnt_q && !pend_s1) state_q <= S_DEC;
				end
				S_DEC: begin
					rd_q   <= '0;
					wr_q   <= '0;
					ncp_q  <= '0;
					live_q <= cnt_q;
					if (at_thr) begin
						if (refr_q == 8'd0) begin
							pot_q   <= '0;
							spike_q <= 1'b1;
							refr_q  <= cfg.refractory_ticks;
							if (cfg.plastic_enable) state_q <= S_PL;
							else state_q <= S_IDLE;
						end else begin
							refr_q  <= refr_q - 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						if (pot_q[23]) pot_q <= '0;
						state_q <= S_IDLE;
					end
					if (!(at_thr && refr_q == 8'd0 && cfg.plastic_enable)) begin
						odata_q.spike            <= at_thr && (refr_q == 8'd0);
						odata_q.status           <= ST_OK;
						odata_q.live_connections <= 9'(cnt_q);
						ovalid_q                 <= 1'b1;
					end
				end
				S_PL: begin
					if (rd_q < cnt_q) begin
						rd_q    <= rd_q + 1'b1;
						pend_s1 <= 1'b1;
					end
					if (pend_s1) begin
						if (pl_keep) wr_q <= wr_q + 1'b1;
						else live_q <= live_q - 1'b1;
						if (pl_copy) begin
							ncp_q  <= ncp_q + 1'b1;
							live_q <= live_q + 1'b1;
						end
					end
					if (rd_q == cnt_q && !pend_s1) begin
						rd_q    <= '0;
						state_q <= S_CP;
					end
				end
				S_CP: begin
					if (rd_q < ncp_q) begin
						rd_q    <= rd_q + 1'b1;
						pend_s1 <= 1'b1;
					end
					if (pend_s1) wr_q <= wr_q + 1'b1;
					if (rd_q == ncp_q && !pend_s1) begin
						cnt_q                    <= live_q;
						odata_q.spike            <= spike_q;
						odata_q.status           <= ST_OK;
						odata_q.live_connections <= 9'(live_q);
						ovalid_q                 <= 1'b1;
						state_q                  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/snp_ram.sv
// ----------------------------------------------------------------------------
// snp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module snp_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/snp_cfg.sv
// ----------------------------------------------------------------------------
// snp_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module snp_cfg import snp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [22:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	assign cfg = cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fire_threshold    <= 23'd7680;
			cfg_q.refractory_ticks  <= 8'd2;
			cfg_q.weight_range      <= 7'd10;
			cfg_q.plastic_enable    <= 1'b0;
			cfg_q.potentiation_step <= 15'd0;
			cfg_q.depression_step   <= 15'd0;
			cfg_q.connection_limit  <= 9'd150;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: cfg_q.fire_threshold    <= cfg_data;
				REG_REFRACT:   cfg_q.refractory_ticks  <= cfg_data[7:0];
				REG_RANGE:     cfg_q.weight_range      <= cfg_data[6:0];
				REG_PLASTIC:   cfg_q.plastic_enable    <= cfg_data[0];
				REG_POT_STEP:  cfg_q.potentiation_step <= cfg_data[14:0];
				REG_DEP_STEP:  cfg_q.depression_step   <= cfg_data[14:0];
				REG_LIMIT:     cfg_q.connection_limit  <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

endmodule
